>>> src/prmq_pkg.sv
// ----------------------------------------------------------------------------
// prmq_pkg
// Shared widths, opcodes, register indexes and state types for the
// polynomial ring multiplier.
// ----------------------------------------------------------------------------
package prmq_pkg;

	localparam int unsigned QW   = 31;  // modulus q
	localparam int unsigned LENW = 9;   // operand length registers
	localparam int unsigned OPW  = 3;
	localparam int unsigned IDXW = 9;
	localparam int unsigned CW   = 32;  // coefficient
	localparam int unsigned CNTW = 10;  // result count
	localparam int unsigned CFGW = 2;   // register index

	localparam logic [OPW-1:0] OP_LOAD_A  = 3'd0;
	localparam logic [OPW-1:0] OP_LOAD_B  = 3'd1;
	localparam logic [OPW-1:0] OP_LOAD_M  = 3'd2;
	localparam logic [OPW-1:0] OP_COMPUTE = 3'd3;
	localparam logic [OPW-1:0] OP_READ    = 3'd4;

	localparam logic [CFGW-1:0] REG_Q      = 2'd0;
	localparam logic [CFGW-1:0] REG_LEN_A  = 2'd1;
	localparam logic [CFGW-1:0] REG_LEN_B  = 2'd2;
	localparam logic [CFGW-1:0] REG_RED_EN = 2'd3;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_CLR,
		S_TOP_RD,
		S_TOP_CHK,
		S_MUL_RD,
		S_MUL_MUL,
		S_MUL_ADD,
		S_MUL_DIV,
		S_MUL_WR,
		S_MUL_END,
		S_RED_D,
		S_RED_LEAD_RD,
		S_RED_LEAD_CHK,
		S_RED_RD,
		S_RED_MUL,
		S_RED_ADD,
		S_RED_DIV,
		S_RED_WR,
		S_RED_END,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_ABS,
		R_DIV,
		R_FIN
	} red_state_t;

endpackage

>>> src/prmq_req_if.sv
// ----------------------------------------------------------------------------
// prmq_req_if
// Item channel into the multiplier: opcode, index and coefficient.
// ----------------------------------------------------------------------------
interface prmq_req_if;
	import prmq_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OPW-1:0]         opcode;
	logic [IDXW-1:0]        coeff_index;
	logic signed [CW-1:0]   coeff_in;

	modport source (output valid, opcode, coeff_index, coeff_in, input ready);
	modport sink   (input valid, opcode, coeff_index, coeff_in, output ready);
endinterface

>>> src/prmq_rsp_if.sv
// ----------------------------------------------------------------------------
// prmq_rsp_if
// Result channel out of the multiplier: one result per item.
// ----------------------------------------------------------------------------
interface prmq_rsp_if;
	import prmq_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [CW-1:0]   read_value;
	logic [CNTW-1:0]        result_count;
	logic                   index_error;

	modport source (output valid, read_value, result_count, index_error, input ready);
	modport sink   (input valid, read_value, result_count, index_error, output ready);
endinterface

>>> src/prmq_reduce.sv
// ----------------------------------------------------------------------------
// prmq_reduce
// Bit-serial signed remainder v % q (truncating, sign of v kept).
// q == 0 passes the low 32 bits through.
// ----------------------------------------------------------------------------
module prmq_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  v,
	input  logic [30:0]         q,
	output logic                done,
	output logic signed [31:0]  res
);
	import prmq_pkg::*;

	red_state_t         state_q, state_nx;
	logic signed [63:0] v_q;
	logic [63:0]        mag_q;
	logic [31:0]        rem_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic [31:0]        trial;

	assign trial = {rem_q[30:0], mag_q[63]};

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			R_IDLE: if (start) state_nx = (q == '0) ? R_FIN : R_ABS;
			R_ABS:  state_nx = R_DIV;
			R_DIV:  if (cnt_q == 6'd63) state_nx = R_FIN;
			R_FIN:  state_nx = R_IDLE;
			default: state_nx = R_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == R_FIN);
		res  = neg_q ? -rem_q : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= R_IDLE;
		else         state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				v_q   <= v;
				rem_q <= v[31:0];
				neg_q <= 1'b0;
			end
			R_ABS: begin
				mag_q <= v_q[63] ? 64'(-v_q) : 64'(v_q);
				neg_q <= v_q[63];
				rem_q <= '0;
				cnt_q <= '0;
			end
			R_DIV: begin
				// restoring step: remainder stays below q < 2^31
				if (trial >= {1'b0, q}) rem_q <= trial - {1'b0, q};
				else                    rem_q <= trial;
				mag_q <= {mag_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			R_FIN: ;
			default: ;
		endcase
	end
endmodule

>>> src/poly_ring_multiply_mod_q.sv
// ----------------------------------------------------------------------------
// poly_ring_multiply_mod_q
// Schoolbook polynomial multiply with coefficients mod q and optional
// reduction by a stored monic modulus polynomial.
//
//   channel  dir  transfer carries
//   req      in   opcode, coeff_index, coeff_in
//   rsp      out  read_value, result_count, index_error
//   cfg      in   cfg_we, cfg_idx, cfg_data (no handshake)
//
// Load items are taken in the idle state, in-range read items pass through the
// read state. A compute item clears the product store, finds the top modulus
// term, runs each accumulation through the 64-step bit-serial remainder unit
// (bypassed when q is zero), then the reduction walk if it is enabled.
// After reset the modulus store is cleared while req.ready is low.
// req.ready is low while an item is in work or a result waits on rsp.
// ----------------------------------------------------------------------------
module poly_ring_multiply_mod_q #(
	parameter int MAX_LEN = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	prmq_req_if.sink                    req,
	prmq_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [prmq_pkg::CFGW-1:0]   cfg_idx,
	input  logic [prmq_pkg::QW-1:0]     cfg_data
);
	import prmq_pkg::*;

	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int MW  = $clog2(MAX_LEN + 1);
	localparam int PW  = $clog2(2 * MAX_LEN);
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int PLW = $clog2(2 * MAX_LEN + 1);

	// configuration
	logic [QW-1:0]   q_q;
	logic [LENW-1:0] len_a_q, len_b_q;
	logic            red_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q      <= QW'(12289);
			len_a_q  <= LENW'(256);
			len_b_q  <= LENW'(256);
			red_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_Q:      q_q      <= cfg_data;
				REG_LEN_A:  len_a_q  <= cfg_data[LENW-1:0];
				REG_LEN_B:  len_b_q  <= cfg_data[LENW-1:0];
				REG_RED_EN: red_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// memories
	logic signed [CW-1:0] a_mem [MAX_LEN];
	logic signed [CW-1:0] b_mem [MAX_LEN];
	logic signed [CW-1:0] m_mem [MAX_LEN+1];
	logic signed [CW-1:0] p_mem [2*MAX_LEN];
	logic signed [CW-1:0] a_rd_q, b_rd_q, m_rd_q, p_rd_q;

	state_t            state_q, state_nx;
	logic [LW-1:0]     i_q, j_q, la_q, lb_q;
	logic [MW-1:0]     k_q, top_q, jj_q, clr_q;
	logic [PW-1:0]     pc_q;
	logic [PLW-1:0]    d_q, count_q;
	logic signed [32:0] factor_q;
	logic signed [63:0] mul_s1;
	logic signed [CW-1:0] res_q;
	logic              out_valid_q;
	logic signed [CW-1:0] out_val_q;
	logic              out_err_q;

	logic              acc;
	logic [31:0]       idx32;
	logic              idx_ok_ab, idx_ok_m, rd_ok;
	logic [AW-1:0]     a_raddr, b_raddr;
	logic [MW-1:0]     m_raddr;
	logic [PW-1:0]     p_raddr;
	logic              p_we, m_we;
	logic [PW-1:0]     p_waddr;
	logic [MW-1:0]     m_waddr;
	logic signed [CW-1:0] p_wdata, m_wdata;
	logic              emit;
	logic signed [CW-1:0] emit_val;
	logic              emit_err;
	logic signed [32:0] mul_op1;
	logic signed [31:0] mul_op2;
	logic signed [64:0] mul_full;
	logic              red_start, red_done;
	logic signed [63:0] red_v;
	logic signed [31:0] red_res;
	logic [LW-1:0]     la_cl, lb_cl;
	logic              in_red;

	assign acc       = req.valid & req.ready;
	assign idx32     = 32'(req.coeff_index);
	assign idx_ok_ab = idx32 < 32'(MAX_LEN);
	assign idx_ok_m  = idx32 <= 32'(MAX_LEN);
	assign rd_ok     = idx32 < 32'(count_q);
	assign la_cl     = (32'(len_a_q) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(len_a_q);
	assign lb_cl     = (32'(len_b_q) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(len_b_q);
	assign in_red    = (state_q == S_RED_RD) || (state_q == S_RED_MUL) ||
	                   (state_q == S_RED_ADD);

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);

	// shared multiplier, registered
	assign mul_op1  = in_red ? factor_q : {a_rd_q[31], a_rd_q};
	assign mul_op2  = in_red ? m_rd_q : b_rd_q;
	assign mul_full = mul_op1 * mul_op2;

	assign red_start = (state_q == S_MUL_ADD) || (state_q == S_RED_ADD);
	assign red_v     = {{32{p_rd_q[31]}}, p_rd_q} + mul_s1;

	prmq_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.v      (red_v),
		.q      (q_q),
		.done   (red_done),
		.res    (red_res)
	);

	// read addresses
	assign a_raddr = i_q[AW-1:0];
	assign b_raddr = j_q[AW-1:0];

	always_comb begin
		p_raddr = '0;
		m_raddr = k_q;
		unique case (state_q)
			S_IDLE: p_raddr = idx32[PW-1:0];
			S_MUL_RD, S_MUL_MUL, S_MUL_ADD: p_raddr = PW'(i_q) + PW'(j_q);
			S_RED_LEAD_RD, S_RED_LEAD_CHK: p_raddr = d_q[PW-1:0];
			S_RED_RD, S_RED_MUL, S_RED_ADD: begin
				p_raddr = d_q[PW-1:0] - PW'(jj_q);
				m_raddr = top_q - jj_q;
			end
			default: ;
		endcase
	end

	// write ports
	always_comb begin
		p_we    = 1'b0;
		p_waddr = pc_q;
		p_wdata = '0;
		m_we    = 1'b0;
		m_waddr = clr_q;
		m_wdata = '0;
		unique case (state_q)
			S_INIT: m_we = 1'b1;
			S_IDLE: begin
				if (acc && req.opcode == OP_LOAD_M && idx_ok_m) begin
					m_we    = 1'b1;
					m_waddr = idx32[MW-1:0];
					m_wdata = req.coeff_in;
				end
			end
			S_CLR: p_we = 1'b1;
			S_MUL_WR: begin
				p_we    = 1'b1;
				p_waddr = PW'(i_q) + PW'(j_q);
				p_wdata = res_q;
			end
			S_RED_WR: begin
				p_we    = 1'b1;
				p_waddr = d_q[PW-1:0] - PW'(jj_q);
				p_wdata = res_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && req.opcode == OP_LOAD_A && idx_ok_ab)
			a_mem[idx32[AW-1:0]] <= req.coeff_in;
		if (acc && req.opcode == OP_LOAD_B && idx_ok_ab)
			b_mem[idx32[AW-1:0]] <= req.coeff_in;
		if (m_we) m_mem[m_waddr] <= m_wdata;
		if (p_we) p_mem[p_waddr] <= p_wdata;
		a_rd_q <= a_mem[a_raddr];
		b_rd_q <= b_mem[b_raddr];
		m_rd_q <= m_mem[m_raddr];
		p_rd_q <= p_mem[p_raddr];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_INIT: if (clr_q == MW'(MAX_LEN)) state_nx = S_IDLE;
			S_IDLE: begin
				if (acc) begin
					if (req.opcode == OP_COMPUTE)            state_nx = S_CLR;
					else if (req.opcode == OP_READ && rd_ok) state_nx = S_READ;
				end
			end
			S_READ: state_nx = S_IDLE;
			S_CLR: if (pc_q == PW'(2 * MAX_LEN - 1)) state_nx = S_TOP_RD;
			S_TOP_RD: state_nx = S_TOP_CHK;
			S_TOP_CHK: begin
				if (k_q != MW'(MAX_LEN))             state_nx = S_TOP_RD;
				else if (la_q == '0 || lb_q == '0)   state_nx = S_MUL_END;
				else                                 state_nx = S_MUL_RD;
			end
			S_MUL_RD:  state_nx = S_MUL_MUL;
			S_MUL_MUL: state_nx = S_MUL_ADD;
			S_MUL_ADD: state_nx = S_MUL_DIV;
			S_MUL_DIV: if (red_done) state_nx = S_MUL_WR;
			S_MUL_WR: begin
				if (j_q == lb_q - LW'(1) && i_q == la_q - LW'(1)) state_nx = S_MUL_END;
				else                                                state_nx = S_MUL_RD;
			end
			S_MUL_END: state_nx = red_en_q ? S_RED_D : S_DONE;
			S_RED_D: state_nx = (32'(d_q) > 32'(top_q)) ? S_RED_LEAD_RD : S_RED_END;
			S_RED_LEAD_RD:  state_nx = S_RED_LEAD_CHK;
			S_RED_LEAD_CHK: state_nx = (p_rd_q != '0) ? S_RED_RD : S_RED_D;
			S_RED_RD:  state_nx = S_RED_MUL;
			S_RED_MUL: state_nx = S_RED_ADD;
			S_RED_ADD: state_nx = S_RED_DIV;
			S_RED_DIV: if (red_done) state_nx = S_RED_WR;
			S_RED_WR:  state_nx = (jj_q == top_q) ? S_RED_D : S_RED_RD;
			S_RED_END: state_nx = S_DONE;
			S_DONE:    state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	// result generation
	always_comb begin
		emit     = 1'b0;
		emit_val = '0;
		emit_err = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req.opcode)
						OP_LOAD_A, OP_LOAD_B: begin
							emit     = 1'b1;
							emit_err = !idx_ok_ab;
						end
						OP_LOAD_M: begin
							emit     = 1'b1;
							emit_err = !idx_ok_m;
						end
						OP_COMPUTE: ;
						OP_READ: begin
							emit     = !rd_ok;
							emit_err = !rd_ok;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_READ: begin
				emit     = 1'b1;
				emit_val = p_rd_q;
			end
			S_DONE: emit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			clr_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (emit)           out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (state_q == S_INIT)    clr_q   <= clr_q + MW'(1);
			if (state_q == S_MUL_END) count_q <= PLW'(la_q) + PLW'(lb_q);
			if (state_q == S_RED_END) count_q <= PLW'(top_q);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_val_q <= emit_val;
			out_err_q <= emit_err;
		end
		mul_s1 <= mul_full[63:0];
		unique case (state_q)
			S_IDLE: begin
				pc_q <= '0;
				la_q <= la_cl;
				lb_q <= lb_cl;
			end
			S_CLR: begin
				pc_q  <= pc_q + PW'(1);
				k_q   <= '0;
				top_q <= '0;
			end
			S_TOP_CHK: begin
				if (m_rd_q != '0) top_q <= k_q;
				k_q <= k_q + MW'(1);
				i_q <= '0;
				j_q <= '0;
			end
			S_MUL_DIV: if (red_done) res_q <= red_res;
			S_MUL_WR: begin
				if (j_q == lb_q - LW'(1)) begin
					j_q <= '0;
					i_q <= i_q + LW'(1);
				end else begin
					j_q <= j_q + LW'(1);
				end
			end
			S_MUL_END: d_q <= PLW'(la_q) + PLW'(lb_q);
			S_RED_D: if (32'(d_q) > 32'(top_q)) d_q <= d_q - PLW'(1);
			S_RED_LEAD_CHK: begin
				factor_q <= -{p_rd_q[31], p_rd_q};
				jj_q     <= '0;
			end
			S_RED_DIV: if (red_done) res_q <= red_res;
			S_RED_WR: jj_q <= jj_q + MW'(1);
			default: ;
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_value   = out_val_q;
	assign rsp.result_count = CNTW'(count_q);
	assign rsp.index_error  = out_err_q;
endmodule
